@@ src/gcpc_pkg.sv @@
// gcpc_pkg: beat types, register indexes, divider step and 2^-x fraction table
// for the chroma pixel classifier. No dependencies.
`default_nettype none
package gcpc_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [15:0] score;
        logic        in_range;
    } result_t;

    typedef enum logic [2:0] {
        REG_SUM_MIN     = 3'd0,
        REG_SUM_MAX     = 3'd1,
        REG_MEAN_RED    = 3'd2,
        REG_MEAN_GREEN  = 3'd3,
        REG_INV_COV_RR  = 3'd4,
        REG_INV_COV_RG  = 3'd5,
        REG_INV_COV_GG  = 3'd6,
        REG_PEAK_SCALE  = 3'd7
    } cfg_index_t;

    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = 4;      // DIV_STAGES * DIV_STEPS = 16 fraction bits
    localparam int EXP_TABLE_MAX = 12;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    // 2^(-2^-(j+1)) in Q0.30
    localparam logic [29:0] EXP_FRAC_FACTOR [EXP_TABLE_MAX] = '{
        30'd759250125,  30'd902905651,  30'd984625594,  30'd1028218693,
        30'd1050733751, 30'd1062175491, 30'd1067942999, 30'd1070838486,
        30'd1072289173, 30'd1073015252, 30'd1073378477, 30'd1073560135
    };

    typedef struct packed {
        logic [9:0]  rem;
        logic [16:0] quo;
    } div_state_t;

    // restoring division, DIV_STEPS quotient bits per call
    function automatic div_state_t div_steps(div_state_t din, logic [9:0] divisor);
        div_state_t  d;
        logic [10:0] trial;
        d = din;
        for (int k = 0; k < DIV_STEPS; k++) begin
            trial = {d.rem, 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                d.rem = 10'(trial - {1'b0, divisor});
                d.quo = {d.quo[15:0], 1'b1};
            end
            else
            begin
                d.rem = trial[9:0];
                d.quo = {d.quo[15:0], 1'b0};
            end
        end
        return d;
    endfunction

endpackage
`default_nettype wire

@@ src/gaussian_chroma_pixel_classifier_unit.sv @@
// A start beat passes divider, arithmetic, mantissa and scale stages to done.
// Throughput: one pixel per clock; busy stays low, the pipeline never stalls.
// Depth is set by the 16-step chroma divider (4 stages) and one multiplier
// stage per fraction bit of the 2^-x mantissa chain.
// Reset clears the valid bits and loads the config registers with defaults.
`default_nettype none
module gaussian_chroma_pixel_classifier_unit
    import gcpc_pkg::*;
#(
    parameter int EXP_TABLE_BITS = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire pixel_t      pixel,
    output logic             done,
    output result_t          result,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int LATENCY = 14 + EXP_TABLE_BITS;
    localparam logic signed [51:0] TAIL_LIMIT = 52'sd2199023255552;   // 2^41

    // configuration
    logic [9:0]         sum_min_reg, sum_max_reg;
    logic [15:0]        mean_red_reg, mean_green_reg, peak_scale_reg;
    logic signed [15:0] inv_cov_rr_reg, inv_cov_rg_reg, inv_cov_gg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_min_reg    <= 10'd0;
            sum_max_reg    <= 10'd765;
            mean_red_reg   <= 16'd22396;
            mean_green_reg <= 16'd15799;
            inv_cov_rr_reg <= 16'sd10019;
            inv_cov_rg_reg <= -16'sd5866;
            inv_cov_gg_reg <= 16'sd13453;
            peak_scale_reg <= 16'd1595;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_SUM_MIN:    sum_min_reg    <= cfg_data[9:0];
                REG_SUM_MAX:    sum_max_reg    <= cfg_data[9:0];
                REG_MEAN_RED:   mean_red_reg   <= cfg_data;
                REG_MEAN_GREEN: mean_green_reg <= cfg_data;
                REG_INV_COV_RR: inv_cov_rr_reg <= signed'(cfg_data);
                REG_INV_COV_RG: inv_cov_rg_reg <= signed'(cfg_data);
                REG_INV_COV_GG: inv_cov_gg_reg <= signed'(cfg_data);
                REG_PEAK_SCALE: peak_scale_reg <= cfg_data;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---- accept: sum, range check, divider seed
    logic [9:0] sum_next;
    logic       ok_next;
    div_state_t seed_r_next, seed_g_next;

    always_comb
    begin
        sum_next = {2'b00, pixel.red} + {2'b00, pixel.green} + {2'b00, pixel.blue};
        ok_next  = (sum_next != 10'd0) && (sum_next >= sum_min_reg)
                   && (sum_next <= sum_max_reg);
        seed_r_next.quo = {16'd0, ({2'b00, pixel.red} == sum_next)};
        seed_r_next.rem = seed_r_next.quo[0] ? 10'd0 : {2'b00, pixel.red};
        seed_g_next.quo = {16'd0, ({2'b00, pixel.green} == sum_next)};
        seed_g_next.rem = seed_g_next.quo[0] ? 10'd0 : {2'b00, pixel.green};
    end

    logic       dv_valid_reg [DIV_STAGES+1];
    logic       dv_ok_reg    [DIV_STAGES+1];
    logic [9:0] dv_sum_reg   [DIV_STAGES+1];
    div_state_t dv_r_reg     [DIV_STAGES+1];
    div_state_t dv_g_reg     [DIV_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else
            dv_valid_reg[0] <= start & ~busy;
    end

    always_ff @(posedge clk)
    begin
        dv_ok_reg[0]  <= ok_next;
        dv_sum_reg[0] <= sum_next;
        dv_r_reg[0]   <= seed_r_next;
        dv_g_reg[0]   <= seed_g_next;
    end

    // ---- divider stages
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            dv_ok_reg[k+1]  <= dv_ok_reg[k];
            dv_sum_reg[k+1] <= dv_sum_reg[k];
            dv_r_reg[k+1]   <= div_steps(dv_r_reg[k], dv_sum_reg[k]);
            dv_g_reg[k+1]   <= div_steps(dv_g_reg[k], dv_sum_reg[k]);
        end
    end

    // ---- arithmetic stages: control travels as a valid/ok pair
    logic               d_valid_reg, sq_valid_reg, w_valid_reg, t_valid_reg;
    logic               c_valid_reg, m_valid_reg;
    logic               d_ok_reg, sq_ok_reg, w_ok_reg, t_ok_reg, c_ok_reg, m_ok_reg;
    logic signed [17:0] dr_reg, dg_reg;
    logic [32:0]        drr_reg, dgg_reg;
    logic signed [35:0] drg_reg;
    logic signed [49:0] wrr_reg, wgg_reg;
    logic signed [51:0] wrg_reg;
    logic signed [51:0] t_reg;
    logic               c_tail_reg, c_neg_reg, m_tail_reg, m_neg_reg;
    logic [41:0]        mag_reg;
    logic [37:0]        plo_reg, phi_reg;

    logic signed [17:0] dr_next, dg_next;
    logic signed [35:0] prr_next, pgg_next;
    logic signed [51:0] t_next;
    logic               tail_next, neg_next;
    logic [41:0]        mag_next;
    logic [58:0]        prod_next;
    logic [21:0]        xmag_next;
    logic signed [21:0] x16_next;

    always_comb
    begin
        dr_next   = signed'({1'b0, dv_r_reg[DIV_STAGES].quo}) - signed'({2'b00, mean_red_reg});
        dg_next   = signed'({1'b0, dv_g_reg[DIV_STAGES].quo}) - signed'({2'b00, mean_green_reg});
        prr_next  = dr_reg * dr_reg;
        pgg_next  = dg_reg * dg_reg;
        t_next    = 52'(wrr_reg) + (wrg_reg <<< 1) + 52'(wgg_reg);
        tail_next = t_reg > TAIL_LIMIT;
        neg_next  = t_reg[51];
        if (t_reg < -TAIL_LIMIT)
            mag_next = 42'h200_0000_0000;
        else if (neg_next)
            mag_next = 42'(-t_reg);
        else
            mag_next = t_reg[41:0];
        prod_next = {phi_reg, 21'd0} + {21'd0, plo_reg};
        if (m_neg_reg)
            xmag_next = 22'((prod_next + 59'h1f_ffff_ffff) >> 37);
        else
            xmag_next = prod_next[58:37];
        x16_next  = m_neg_reg ? -signed'(xmag_next) : signed'(xmag_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg  <= 1'b0;
            sq_valid_reg <= 1'b0;
            w_valid_reg  <= 1'b0;
            t_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            d_valid_reg  <= dv_valid_reg[DIV_STAGES];
            sq_valid_reg <= d_valid_reg;
            w_valid_reg  <= sq_valid_reg;
            t_valid_reg  <= w_valid_reg;
            c_valid_reg  <= t_valid_reg;
            m_valid_reg  <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_ok_reg   <= dv_ok_reg[DIV_STAGES];
        dr_reg     <= dr_next;
        dg_reg     <= dg_next;
        sq_ok_reg  <= d_ok_reg;
        drr_reg    <= prr_next[32:0];
        dgg_reg    <= pgg_next[32:0];
        drg_reg    <= dr_reg * dg_reg;
        w_ok_reg   <= sq_ok_reg;
        wrr_reg    <= signed'({1'b0, drr_reg}) * inv_cov_rr_reg;
        wgg_reg    <= signed'({1'b0, dgg_reg}) * inv_cov_gg_reg;
        wrg_reg    <= drg_reg * inv_cov_rg_reg;
        t_ok_reg   <= w_ok_reg;
        t_reg      <= t_next;
        c_ok_reg   <= t_ok_reg;
        c_tail_reg <= tail_next;
        c_neg_reg  <= neg_next;
        mag_reg    <= mag_next;
        m_ok_reg   <= c_ok_reg;
        m_tail_reg <= c_tail_reg;
        m_neg_reg  <= c_neg_reg;
        plo_reg    <= {17'd0, mag_reg[20:0]} * {21'd0, LOG2E_Q16};
        phi_reg    <= {17'd0, mag_reg[41:21]} * {21'd0, LOG2E_Q16};
    end

    // ---- mantissa chain, one table factor per stage
    logic                      ex_valid_reg [EXP_TABLE_BITS+1];
    logic                      ex_ok_reg    [EXP_TABLE_BITS+1];
    logic                      ex_tail_reg  [EXP_TABLE_BITS+1];
    logic signed [5:0]         ex_ip_reg    [EXP_TABLE_BITS+1];
    logic [EXP_TABLE_BITS-1:0] ex_f_reg     [EXP_TABLE_BITS+1];
    logic [30:0]               ex_m_reg     [EXP_TABLE_BITS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ex_valid_reg[0] <= 1'b0;
        else
            ex_valid_reg[0] <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        ex_ok_reg[0]   <= m_ok_reg;
        ex_tail_reg[0] <= m_tail_reg;
        ex_ip_reg[0]   <= x16_next[21:16];
        ex_f_reg[0]    <= x16_next[15 -: EXP_TABLE_BITS];
        ex_m_reg[0]    <= 31'h4000_0000;
    end

    for (genvar j = 0; j < EXP_TABLE_BITS; j++)
    begin : g_exp
        logic [60:0] mul_next;

        always_comb
        begin
            mul_next = {30'd0, ex_m_reg[j]} * {31'd0, EXP_FRAC_FACTOR[j]}
                       + 61'h2000_0000;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ex_valid_reg[j+1] <= 1'b0;
            else
                ex_valid_reg[j+1] <= ex_valid_reg[j];
        end

        always_ff @(posedge clk)
        begin
            ex_ok_reg[j+1]   <= ex_ok_reg[j];
            ex_tail_reg[j+1] <= ex_tail_reg[j];
            ex_ip_reg[j+1]   <= ex_ip_reg[j];
            ex_f_reg[j+1]    <= ex_f_reg[j];
            ex_m_reg[j+1]    <= ex_f_reg[j][EXP_TABLE_BITS-1-j] ? mul_next[60:30]
                                                                : ex_m_reg[j];
        end
    end

    // ---- scale, shift, saturate
    logic        p_valid_reg, p_zero_reg, p_ok_reg;
    logic [46:0] p_prod_reg;
    logic [5:0]  p_shift_reg;
    logic [46:0] shifted_next;
    logic [15:0] score_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            done        <= 1'b0;
        end
        else
        begin
            p_valid_reg <= ex_valid_reg[EXP_TABLE_BITS];
            done        <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_ok_reg    <= ex_ok_reg[EXP_TABLE_BITS];
        p_zero_reg  <= ~ex_ok_reg[EXP_TABLE_BITS] | ex_tail_reg[EXP_TABLE_BITS];
        p_prod_reg  <= {31'd0, peak_scale_reg} * {16'd0, ex_m_reg[EXP_TABLE_BITS]};
        p_shift_reg <= 6'd30 + 6'(ex_ip_reg[EXP_TABLE_BITS]);
    end

    always_comb
    begin
        shifted_next = p_prod_reg >> p_shift_reg;
        if (p_zero_reg)
            score_next = 16'd0;
        else if (|shifted_next[46:16])
            score_next = 16'hffff;
        else
            score_next = shifted_next[15:0];
    end

    always_ff @(posedge clk)
    begin
        result.score    <= score_next;
        result.in_range <= p_ok_reg;
    end

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("beat lost in pipeline");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without accepted beat");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.in_range) |-> (result.score == 16'd0))
        else $error("rejected pixel scored");
`endif

endmodule
`default_nettype wire

@@ test/gcpc_checker.sv @@
// gcpc_checker: watches the pixel, result and register ports of the classifier,
// predicts each score and compares it. Depends on gcpc_pkg.
`timescale 1ns / 100ps
module gcpc_checker
    import gcpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire pixel_t      pixel,
    input  wire logic        done,
    input  wire result_t     result,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output int               fail_count,
    output int               pending
);

    localparam int TBITS = 8;
    localparam longint TAIL = 64'sd1 << 41;
    localparam longint unsigned FRAC_C [12] = '{
        759250125, 902905651, 984625594, 1028218693,
        1050733751, 1062175491, 1067942999, 1070838486,
        1072289173, 1073015252, 1073378477, 1073560135
    };

    logic [9:0]  lim_lo, lim_hi;
    logic [15:0] mu_r, mu_g, k_rr, k_rg, k_gg, peak;
    result_t     score_q[$];

    function automatic logic [15:0] likelihood(longint t);
        longint unsigned mag, prod, m;
        longint x16, ip, u;
        int unsigned f;
        int sh;
        if (t > TAIL)
            return 16'd0;
        if (t < -TAIL)
            t = -TAIL;
        if (t >= 0)
        begin
            mag = longint'(t) * 64'd94548;
            x16 = longint'(mag >> 37);
        end
        else
        begin
            mag = longint'(-t) * 64'd94548;
            x16 = -longint'((mag + ((64'd1 << 37) - 1)) >> 37);
        end
        u = x16 + (64'sd64 <<< 16);
        ip = (u >>> 16) - 64;
        f = int'(u & 16'hFFFF) >> (16 - TBITS);
        m = 64'd1 << 30;
        for (int j = 0; j < TBITS; j++)
            if ((f >> (TBITS - 1 - j)) & 1)
                m = (m * FRAC_C[j] + (64'd1 << 29)) >> 30;
        prod = longint'(peak) * m;
        sh = 30 + int'(ip);
        if (sh < 0)
            return (prod != 0) ? 16'hFFFF : 16'd0;
        prod = (sh < 64) ? (prod >> sh) : 64'd0;
        return (prod > 65535) ? 16'hFFFF : prod[15:0];
    endfunction

    function automatic result_t classify(pixel_t p);
        result_t r;
        int s;
        longint cr, cg, dr, dg, t;
        s = p.red + p.green + p.blue;
        r = '0;
        if (s == 0 || s < lim_lo || s > lim_hi)
            return r;
        cr = (longint'(p.red) << 16) / s;
        cg = (longint'(p.green) << 16) / s;
        dr = cr - longint'(mu_r);
        dg = cg - longint'(mu_g);
        t = dr * dr * longint'($signed(k_rr)) + 2 * dr * dg * longint'($signed(k_rg))
          + dg * dg * longint'($signed(k_gg));
        r.score = likelihood(t);
        r.in_range = 1'b1;
        return r;
    endfunction

    assign pending = score_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        if (!rst_n)
        begin
            lim_lo <= 10'd0;
            lim_hi <= 10'd765;
            mu_r <= 16'd22396;
            mu_g <= 16'd15799;
            k_rr <= 16'd10019;
            k_rg <= 16'hE916;
            k_gg <= 16'd13453;
            peak <= 16'd1595;
            fail_count <= 0;
            score_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (score_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result beat %h", result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = score_q.pop_front();
                    if (exp_r !== result)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: score exp %0d got %0d, in_range exp %0d got %0d",
                                     exp_r.score, result.score, exp_r.in_range, result.in_range);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                score_q.insert(score_q.size(), classify(pixel));
            if (cfg_we)
                case (cfg_index_t'(cfg_index))
                    REG_SUM_MIN:    lim_lo <= cfg_data[9:0];
                    REG_SUM_MAX:    lim_hi <= cfg_data[9:0];
                    REG_MEAN_RED:   mu_r <= cfg_data;
                    REG_MEAN_GREEN: mu_g <= cfg_data;
                    REG_INV_COV_RR: k_rr <= cfg_data;
                    REG_INV_COV_RG: k_rg <= cfg_data;
                    REG_INV_COV_GG: k_gg <= cfg_data;
                    REG_PEAK_SCALE: peak <= cfg_data;
                    default: ;
                endcase
        end
    end

endmodule

@@ test/tb.sv @@
// tb: clock, reset, register settings and pixel stimulus for the chroma pixel
// classifier; checking is done in gcpc_checker. Depends on gcpc_pkg.
`timescale 1ns / 100ps
module tb;
    import gcpc_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy, done;
    pixel_t      pixel = '0;
    result_t     result;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    int          fail_count, pending;
    int          gap_pct;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    gaussian_chroma_pixel_classifier_unit dut (.*);
    gcpc_checker chk (.*);

    task automatic send_pixel(input logic [7:0] r, g, b);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        pixel <= '{red: r, green: g, blue: b};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // skin-like pixels near the model mean, with one in four fully random
    task automatic random_pixels(input int n);
        logic [7:0] r, g, b;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
            begin
                r = 8'($urandom);
                g = 8'($urandom);
                b = 8'($urandom);
            end
            else
            begin
                r = 8'($urandom_range(255, 40));
                g = 8'($urandom_range(int'(r) * 3 / 4, int'(r) / 3));
                b = 8'($urandom_range(int'(r) * 3 / 4, int'(r) / 4));
            end
            send_pixel(r, g, b);
        end
    endtask

    initial
    begin
        #200000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        gap_pct = 26;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_pixel(0, 0, 0);
        send_pixel(255, 255, 255);
        send_pixel(255, 0, 0);
        send_pixel(0, 255, 0);
        send_pixel(0, 0, 255);
        send_pixel(1, 0, 0);
        send_pixel(170, 85, 85);
        send_pixel(200, 90, 60);
        send_pixel(85, 170, 0);
        send_pixel(128, 64, 32);
        random_pixels(190);
        drain();
        write_reg(REG_SUM_MIN, 16'd765);
        write_reg(REG_SUM_MAX, 16'd0);
        send_pixel(255, 255, 255);
        send_pixel(100, 50, 40);
        drain();
        write_reg(REG_SUM_MIN, 16'd60);
        write_reg(REG_SUM_MAX, 16'd600);
        write_reg(REG_MEAN_RED, 16'hFFFF);
        write_reg(REG_MEAN_GREEN, 16'd0);
        write_reg(REG_INV_COV_RR, 16'h7FFF);
        write_reg(REG_INV_COV_RG, 16'h8000);
        write_reg(REG_INV_COV_GG, 16'h7FFF);
        write_reg(REG_PEAK_SCALE, 16'hFFFF);
        send_pixel(255, 0, 0);
        send_pixel(20, 20, 20);
        send_pixel(200, 200, 200);
        random_pixels(150);
        drain();
        gap_pct = 46;
        write_reg(REG_SUM_MIN, 16'd0);
        write_reg(REG_SUM_MAX, 16'd765);
        write_reg(REG_MEAN_RED, 16'd21845);
        write_reg(REG_MEAN_GREEN, 16'd21845);
        write_reg(REG_INV_COV_RR, 16'd1);
        write_reg(REG_INV_COV_RG, 16'd0);
        write_reg(REG_INV_COV_GG, 16'd1);
        write_reg(REG_PEAK_SCALE, 16'd0);
        random_pixels(50);
        drain();
        write_reg(REG_PEAK_SCALE, 16'd1);
        random_pixels(100);
        drain();
        write_reg(REG_INV_COV_RR, 16'hFF00);
        write_reg(REG_INV_COV_RG, 16'd300);
        write_reg(REG_INV_COV_GG, 16'h8000);
        write_reg(REG_PEAK_SCALE, 16'd40000);
        random_pixels(100);
        drain();
        gap_pct = 0;
        write_reg(REG_INV_COV_RR, 16'd600);
        write_reg(REG_INV_COV_RG, 16'hFF40);
        write_reg(REG_INV_COV_GG, 16'd800);
        write_reg(REG_PEAK_SCALE, 16'd50000);
        random_pixels(160);
        drain();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
